// File: src/mqmd_pkg.sv
// Shared widths, types and constants of the max queue.
package mqmd_pkg;

   localparam int DEPTH = 16;
   localparam int DATAW = 32;
   localparam int IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW  = $clog2(DEPTH + 1);

   typedef logic signed [DATAW-1:0] data_type;
   typedef logic [IDXW-1:0]         idx_type;
   typedef logic [CNTW-1:0]         cnt_type;

   localparam cnt_type       DEPTH_CNT = CNTW'(DEPTH);
   localparam logic [CNTW:0] DEPTH_SUM = (CNTW + 1)'(DEPTH);

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

endpackage

// File: src/max_queue_monotonic_deque.sv
// Max queue: FIFO of signed words with a descending helper deque for the running maximum.
// Push: the value is written to the queue; S_SCAN drops smaller entries from the deque back,
// then appends it. Pop: S_POP reads the head; S_LOAD reloads the front when it is dropped.
// Errors go straight to S_FIN. One item in flight; ready returns as the result goes valid.
// Synchronous active-high reset empties queue and deque; store contents are not cleared.
module max_queue_monotonic_deque (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  mqmd_pkg::data_type req_push_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mqmd_pkg::data_type rsp_popped_value,
   output mqmd_pkg::data_type rsp_max_value,
   output logic              rsp_is_empty,
   output logic              rsp_error
);
   import mqmd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_POP  = 3'd2;
   localparam logic [2:0] S_LOAD = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   function automatic idx_type wrap_add(idx_type base, cnt_type off);
      logic [CNTW:0] s;
      s = (CNTW + 1)'(base) + (CNTW + 1)'(off);
      if (s >= DEPTH_SUM) begin
         s = s - DEPTH_SUM;
      end
      return idx_type'(s);
   endfunction

   data_type queue_mem [DEPTH];
   data_type deque_mem [DEPTH];

   logic [2:0] state_ff, state_in;
   idx_type    q_head_ff, q_head_in;
   cnt_type    q_count_ff, q_count_in;
   idx_type    d_head_ff, d_head_in;
   cnt_type    d_count_ff, d_count_in;
   data_type   value_ff, value_in;
   data_type   front_ff, front_in;
   data_type   popped_ff, popped_in;
   logic       err_ff, err_in;
   data_type   q_rd_ff;
   data_type   d_rd_ff;
   idx_type    d_rd_addr;
   logic       q_wr_en;
   logic       d_wr_en;
   idx_type    d_wr_addr;

   logic       rsp_valid_ff, rsp_valid_in;
   data_type   rsp_popped_ff, rsp_popped_in;
   data_type   rsp_max_ff, rsp_max_in;
   logic       rsp_empty_ff, rsp_empty_in;
   logic       rsp_error_ff, rsp_error_in;

   logic       accept;
   logic       slot_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      q_head_in     = q_head_ff;
      q_count_in    = q_count_ff;
      d_head_in     = d_head_ff;
      d_count_in    = d_count_ff;
      value_in      = value_ff;
      front_in      = front_ff;
      popped_in     = popped_ff;
      err_in        = err_ff;
      q_wr_en       = 1'b0;
      d_wr_en       = 1'b0;
      d_wr_addr     = wrap_add(d_head_ff, d_count_ff);
      d_rd_addr     = wrap_add(d_head_ff, d_count_ff - cnt_type'(1));
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_popped_in = rsp_popped_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_error_in  = rsp_error_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in  = req_push_value;
               popped_in = '0;
               err_in    = 1'b0;
               if (req_kind == KIND_PUSH) begin
                  if (q_count_ff == DEPTH_CNT) begin
                     err_in   = 1'b1;
                     state_in = S_FIN;
                  end else begin
                     q_wr_en    = 1'b1;
                     q_count_in = q_count_ff + cnt_type'(1);
                     state_in   = S_SCAN;
                  end
               end else begin
                  if (q_count_ff == '0) begin
                     err_in   = 1'b1;
                     state_in = S_FIN;
                  end else begin
                     q_head_in  = wrap_add(q_head_ff, cnt_type'(1));
                     q_count_in = q_count_ff - cnt_type'(1);
                     state_in   = S_POP;
                  end
               end
            end
         end
         S_SCAN: begin
            // d_rd_ff holds the current deque back
            d_rd_addr = wrap_add(d_head_ff, d_count_ff - cnt_type'(2));
            if (d_count_ff != '0 && d_rd_ff < value_ff) begin
               d_count_in = d_count_ff - cnt_type'(1);
            end else begin
               if (d_count_ff != DEPTH_CNT) begin
                  d_wr_en    = 1'b1;
                  d_count_in = d_count_ff + cnt_type'(1);
                  if (d_count_ff == '0) begin
                     front_in = value_ff;
                  end
               end
               state_in = S_FIN;
            end
         end
         S_POP: begin
            popped_in = q_rd_ff;
            d_rd_addr = wrap_add(d_head_ff, cnt_type'(1));
            if (d_count_ff != '0 && front_ff == q_rd_ff) begin
               d_head_in  = wrap_add(d_head_ff, cnt_type'(1));
               d_count_in = d_count_ff - cnt_type'(1);
               state_in   = S_LOAD;
            end else begin
               state_in = S_FIN;
            end
         end
         S_LOAD: begin
            front_in = d_rd_ff;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_popped_in = popped_ff;
               rsp_max_in    = (q_count_ff != '0 && d_count_ff != '0) ? front_ff : '0;
               rsp_empty_in  = (q_count_ff == '0);
               rsp_error_in  = err_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_wr_en) begin
         queue_mem[wrap_add(q_head_ff, q_count_ff)] <= value_in;
      end
      q_rd_ff <= queue_mem[q_head_ff];
      if (d_wr_en) begin
         deque_mem[d_wr_addr] <= value_ff;
      end
      d_rd_ff <= deque_mem[d_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         q_head_ff    <= '0;
         q_count_ff   <= '0;
         d_head_ff    <= '0;
         d_count_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         q_head_ff    <= q_head_in;
         q_count_ff   <= q_count_in;
         d_head_ff    <= d_head_in;
         d_count_ff   <= d_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      front_ff      <= front_in;
      popped_ff     <= popped_in;
      err_ff        <= err_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_max_value    = rsp_max_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_error        = rsp_error_ff;

   a_deque_within_queue: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> d_count_ff <= q_count_ff)
      else $error("deque holds more entries than queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= DEPTH_CNT)
      else $error("queue count beyond depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("item accepted while previous one in work");

   a_empty_max_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_max_ff == '0)
      else $error("nonzero maximum reported for empty queue");

   a_error_no_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_error_ff |-> rsp_popped_ff == '0)
      else $error("popped value on failed item");

endmodule
